>>> hw/rtl/gpg_pkg.sv
// Shared constants, codes and types of the GPIO pin ownership guard.
package gpg_pkg;

   // Port geometry
   localparam int PINS_PER_PORT = 8;
   localparam int NUM_PORTS     = 2;

   // Field widths of one transaction
   localparam int FUNC_W   = 3;
   localparam int PORT_W   = 1;
   localparam int PIN_W    = 3;
   localparam int PID_W    = 7;
   localparam int LEVELS_W = 8;
   localparam int STATUS_W = 2;
   localparam int BITS_W   = 8;

   // Stream widths
   localparam int REQ_USER_W = FUNC_W + PORT_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_REQUEST     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DIR_OUT     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DIR_IN      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE     = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ        = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_WRITE       = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE_ALL = 3'd6;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TAKEN     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_B = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_D = 1'd1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the accepted request
      logic commit;  // execute it and fill the response register
   } cmd_type;

endpackage

>>> hw/rtl/gpio_pin_ownership_guard_core.sv
// Top level of the GPIO pin ownership guard.
//
// Requests enter on the req_ stream: tuser carries the operation and the
// port, tdata the pin, process id, write level and sampled pin levels.
// Each request yields one response on the rsp_ stream with a status, the
// read level and the direction and output latches of the addressed port
// after the operation. Reserved pin masks are written on the csr_ channel,
// which is always ready; write it only while no request is in flight.
// A request accepted in the idle state is captured into the request
// registers; the execute state then runs it and fills the response
// register, whose valid is registered. A new request is accepted only
// once the previous one has executed. This order is set by the two-state
// controller (capture, execute) that handles one request at a time.
// Reset clears the taken masks, the latches, the reserved masks and the
// response valid. When the receiver stalls, the response waits in the
// output register; one more request is accepted and held at the execute
// step until that register is drained.
module gpio_pin_ownership_guard_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // func[2:0], port_sel[3]
   input  logic [gpg_pkg::REQ_USER_W-1:0]      req_tuser,
   // pin_index[2:0], pid[9:3], level_in[10], pin_levels[18:11], zeros above
   input  logic [gpg_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], read_level[2], dir_bits[10:3], out_bits[18:11], zeros above
   output logic [gpg_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gpg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gpg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   gpg_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   gpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   gpg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   // One request in flight: no transaction right after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A response appears only after an execute step
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("response valid without execution");

   // Read level is zero unless the status is ok
   a_read_level_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != gpg_pkg::ST_OK) |-> !rsp_tdata[2])
      else $error("read level set on failed operation");

   // No execution and no request at once
   a_exec_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !cmd.load)
      else $error("load and execute in the same cycle");

endmodule

>>> hw/rtl/gpg_ctrl.sv
// Controller of the pin ownership guard: transaction sequencing and response valid.
module gpg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output gpg_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      commit;

   // Request taken only while no request is in flight
   assign req_tready = (state_ff == S_IDLE);
   // Execute once the response register is free or being drained
   assign commit     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.commit = commit;
   assign rsp_tvalid = rsp_valid_ff;

   // State and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (commit) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (commit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

>>> hw/rtl/gpg_datapath.sv
// Datapath of the pin ownership guard: ownership state, latches and response register.
module gpg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  gpg_pkg::cmd_type                    cmd,
   input  logic                                csr_we,
   input  logic [gpg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gpg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [gpg_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic [gpg_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic [gpg_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int PINS = gpg_pkg::PINS_PER_PORT;
   localparam int PRTS = gpg_pkg::NUM_PORTS;

   // Configuration
   logic [gpg_pkg::CSR_DATA_W-1:0] reserved_b_ff;
   logic [gpg_pkg::CSR_DATA_W-1:0] reserved_d_ff;

   // Captured request
   logic [gpg_pkg::FUNC_W-1:0]   func_ff;
   logic [gpg_pkg::PORT_W-1:0]   port_ff;
   logic [gpg_pkg::PIN_W-1:0]    pin_ff;
   logic [gpg_pkg::PID_W-1:0]    pid_ff;
   logic                         level_ff;
   logic [gpg_pkg::LEVELS_W-1:0] levels_ff;

   // Ownership state; an owner entry counts only while its taken bit is set
   logic [PINS-1:0]              taken_ff [PRTS];
   logic [PINS-1:0]              dir_ff   [PRTS];
   logic [PINS-1:0]              out_ff   [PRTS];
   logic [gpg_pkg::PID_W-1:0]    owner_ff [PRTS][PINS];

   // Response register
   logic [gpg_pkg::STATUS_W-1:0] status_ff;
   logic                         rd_ff;
   logic [gpg_pkg::BITS_W-1:0]   dir_bits_ff;
   logic [gpg_pkg::BITS_W-1:0]   out_bits_ff;

   // Step logic
   logic                         port_ok;
   logic                         pin_ok;
   logic [gpg_pkg::PORT_W-1:0]   psel;
   logic [PINS-1:0]              mask;
   logic [PINS-1:0]              taken_row;
   logic [PINS-1:0]              dir_row;
   logic [PINS-1:0]              out_row;
   logic [PINS-1:0]              reserve_row;
   logic [PINS-1:0]              mine;
   logic                         owned;
   logic [PINS-1:0]              taken_in;
   logic [PINS-1:0]              dir_in;
   logic [PINS-1:0]              out_in;
   logic                         own_we;
   logic [gpg_pkg::STATUS_W-1:0] status_in;
   logic                         rd_in;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_b_ff <= '0;
         reserved_d_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            gpg_pkg::CSR_RESERVED_B: reserved_b_ff <= csr_wdata;
            gpg_pkg::CSR_RESERVED_D: reserved_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request capture: tuser = func, port_sel; tdata = pin, pid, level, levels
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_tuser[2:0];
         port_ff   <= req_tuser[3];
         pin_ff    <= req_tdata[2:0];
         pid_ff    <= req_tdata[9:3];
         level_ff  <= req_tdata[10];
         levels_ff <= req_tdata[18:11];
      end
   end

   // Row selection and ownership checks
   always_comb begin
      port_ok   = (32'(port_ff) < PRTS);
      pin_ok    = (32'(pin_ff) < PINS);
      psel      = port_ok ? port_ff : '0;
      mask      = pin_ok ? (PINS'(1) << pin_ff) : '0;
      taken_row = taken_ff[psel];
      dir_row   = dir_ff[psel];
      out_row   = out_ff[psel];
      case (psel)
         1'd0:    reserve_row = PINS'(reserved_b_ff);
         1'd1:    reserve_row = PINS'(reserved_d_ff);
         default: reserve_row = '0;
      endcase
      for (int i = 0; i < PINS; i++) begin
         mine[i] = taken_row[i] && (owner_ff[psel][i] == pid_ff);
      end
      owned = |(mine & mask);
   end

   // Operation decode and next latch values
   always_comb begin
      taken_in  = taken_row;
      dir_in    = dir_row;
      out_in    = out_row;
      own_we    = 1'b0;
      status_in = gpg_pkg::ST_OK;
      rd_in     = 1'b0;
      if (!port_ok) begin
         status_in = gpg_pkg::ST_UNKNOWN;
      end else if (func_ff == gpg_pkg::FUNC_REQUEST) begin
         if (!pin_ok || |((reserve_row | taken_row) & mask)) begin
            status_in = gpg_pkg::ST_TAKEN;
         end else begin
            taken_in = taken_row | mask;
            own_we   = 1'b1;
         end
      end else if (func_ff == gpg_pkg::FUNC_RELEASE_ALL) begin
         taken_in = taken_row & ~mine;
         dir_in   = dir_row & ~mine;
         out_in   = out_row & ~mine;
      end else if (func_ff > gpg_pkg::FUNC_RELEASE_ALL) begin
         status_in = gpg_pkg::ST_UNKNOWN;
      end else if (!owned) begin
         status_in = gpg_pkg::ST_NOT_OWNER;
      end else begin
         case (func_ff)
            gpg_pkg::FUNC_DIR_OUT: dir_in = dir_row | mask;
            gpg_pkg::FUNC_DIR_IN: begin
               dir_in = dir_row & ~mask;
               out_in = out_row | mask;
            end
            gpg_pkg::FUNC_RELEASE: begin
               taken_in = taken_row & ~mask;
               dir_in   = dir_row & ~mask;
               out_in   = out_row & ~mask;
            end
            gpg_pkg::FUNC_READ:  rd_in  = |(levels_ff & gpg_pkg::LEVELS_W'(mask));
            gpg_pkg::FUNC_WRITE: out_in = level_ff ? (out_row | mask) : (out_row & ~mask);
            default: ;
         endcase
      end
   end

   // Port state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PRTS; p++) begin
            taken_ff[p] <= '0;
            dir_ff[p]   <= '0;
            out_ff[p]   <= '0;
         end
      end else if (cmd.commit && port_ok) begin
         taken_ff[psel] <= taken_in;
         dir_ff[psel]   <= dir_in;
         out_ff[psel]   <= out_in;
      end
   end

   // Owner table write on a granted request
   always_ff @(posedge clock) begin
      if (cmd.commit && own_we) begin
         owner_ff[psel][pin_ff] <= pid_ff;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= status_in;
         rd_ff       <= rd_in;
         dir_bits_ff <= port_ok ? gpg_pkg::BITS_W'(dir_in) : '0;
         out_bits_ff <= port_ok ? gpg_pkg::BITS_W'(out_in) : '0;
      end
   end

   assign rsp_tdata = {5'd0, out_bits_ff, dir_bits_ff, rd_ff, status_ff};

endmodule
